// ===== rtl/lbvs_pkg.sv =====
// shared constants and types for the linear blend vertex skinning engine
package lbvs_pkg;

  localparam int MAX_BONES      = 64;
  localparam int WORDS_PER_BONE = 12;
  localparam int STORE_DEPTH    = MAX_BONES * WORDS_PER_BONE;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int IN_DATA_W      = 208;
  localparam int OUT_DATA_W     = 144;

  typedef logic signed [47:0] nacc_t;
  typedef logic signed [15:0] unit_t;

  typedef struct packed {
    logic done;
    logic zero;
  } nstat_t;

endpackage

// ===== rtl/lbvs_norm.sv =====
// iterative renormalizer: scale, sum of squares, square root and three divisions
module lbvs_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  lbvs_pkg::nacc_t acc_x_i,
  input  lbvs_pkg::nacc_t acc_y_i,
  input  lbvs_pkg::nacc_t acc_z_i,
  output lbvs_pkg::nstat_t stat_o,
  output lbvs_pkg::unit_t unit_x_o,
  output lbvs_pkg::unit_t unit_y_o,
  output lbvs_pkg::unit_t unit_z_o
);
  import lbvs_pkg::*;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SCALE = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DSET  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  function automatic logic [47:0] mag48(input nacc_t a);
    return a[47] ? 48'(-a) : 48'(a);
  endfunction

  logic [2:0]         st_q;
  nacc_t              b_q [3];
  logic [47:0]        m_q;
  logic [4:0]         cnt_q;
  logic [1:0]         idx_q;
  logic signed [63:0] sq_q;
  logic [63:0]        ss_q;
  logic [63:0]        res_q;
  logic [63:0]        v_q;
  logic [47:0]        rem_q;
  logic [16:0]        quo_q;
  unit_t              u_q [3];
  logic               zero_q;

  logic [47:0]        mx, my, mz, mmax;
  logic signed [31:0] bsq;
  logic [63:0]        bitv, trial;
  logic [47:0]        dv;
  logic               ge;
  logic [16:0]        qn;
  logic [47:0]        bfull;
  logic [31:0]        bmag;
  unit_t              uval;

  always_comb begin
    mx   = mag48(acc_x_i);
    my   = mag48(acc_y_i);
    mz   = mag48(acc_z_i);
    mmax = (mx > my) ? mx : my;
    mmax = (mz > mmax) ? mz : mmax;
    bsq  = b_q[cnt_q[1:0]][31:0];
    bitv = 64'(1) << {cnt_q, 1'b0};
    trial = res_q + bitv;
    dv   = 48'(res_q[31:0]) << cnt_q;
    ge   = rem_q >= dv;
    qn   = quo_q | (ge ? (17'(1) << cnt_q) : 17'd0);
    bfull = mag48(b_q[idx_q]);
    bmag = bfull[31:0];
    if (b_q[idx_q][47]) begin
      uval = unit_t'(-$signed({1'b0, qn}));
    end else begin
      uval = (qn > 17'd32767) ? 16'sh7fff : unit_t'(qn[15:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      zero_q <= 1'b0;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else begin
      case (st_q)
        N_IDLE, N_DONE: begin
          if (start_i) begin
            b_q[0] <= acc_x_i;
            b_q[1] <= acc_y_i;
            b_q[2] <= acc_z_i;
            m_q    <= mmax;
            ss_q   <= '0;
            if (mmax == 48'd0) begin
              zero_q <= 1'b1;
              u_q[0] <= '0;
              u_q[1] <= '0;
              u_q[2] <= '0;
              st_q   <= N_DONE;
            end else begin
              zero_q <= 1'b0;
              st_q   <= N_SCALE;
            end
          end
        end
        N_SCALE: begin
          if (m_q < 48'h2000_0000) begin
            m_q    <= m_q << 1;
            b_q[0] <= b_q[0] <<< 1;
            b_q[1] <= b_q[1] <<< 1;
            b_q[2] <= b_q[2] <<< 1;
          end else if (m_q >= 48'h4000_0000) begin
            m_q    <= m_q >> 1;
            b_q[0] <= b_q[0] >>> 1;
            b_q[1] <= b_q[1] >>> 1;
            b_q[2] <= b_q[2] >>> 1;
          end else begin
            cnt_q <= '0;
            st_q  <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_q != 5'd3) begin
            sq_q <= bsq * bsq;
          end
          if (cnt_q != 5'd0) begin
            ss_q <= ss_q + 64'(sq_q);
          end
          if (cnt_q == 5'd3) begin
            v_q   <= ss_q + 64'(sq_q);
            res_q <= '0;
            cnt_q <= 5'd31;
            st_q  <= N_SQRT;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        N_SQRT: begin
          if (v_q >= trial) begin
            v_q   <= v_q - trial;
            res_q <= (res_q >> 1) + bitv;
          end else begin
            res_q <= res_q >> 1;
          end
          if (cnt_q == 5'd0) begin
            idx_q <= '0;
            st_q  <= N_DSET;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        N_DSET: begin
          rem_q <= (48'(bmag) << 15) + 48'(res_q[31:1]);
          quo_q <= '0;
          cnt_q <= 5'd16;
          st_q  <= N_DIV;
        end
        N_DIV: begin
          if (ge) begin
            rem_q <= rem_q - dv;
          end
          quo_q <= qn;
          if (cnt_q == 5'd0) begin
            u_q[idx_q] <= uval;
            if (idx_q == 2'd2) begin
              st_q <= N_DONE;
            end else begin
              idx_q <= idx_q + 2'd1;
              st_q  <= N_DSET;
            end
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        default: st_q <= N_IDLE;
      endcase
    end
  end

  assign stat_o.done = (st_q == N_DONE);
  assign stat_o.zero = zero_q;
  assign unit_x_o    = u_q[0];
  assign unit_y_o    = u_q[1];
  assign unit_z_o    = u_q[2];

endmodule

// ===== rtl/linear_blend_vertex_skinning_core.sv =====
// top level of the linear blend vertex skinning engine
// Usage: one input stream (s_axis) carries two kinds of transaction, told apart by
// s_axis_tuser: 0 writes one Q16.16 bone matrix word into the bone store, 1 is one
// influence of a vertex; s_axis_tlast marks the last influence of the vertex.
// The first influence of a vertex supplies its position and normal.
// On the last influence one result leaves on m_axis: skinned position and unit
// normal in tdata, the zero-normal flag in tuser.
// Flow: a bone word write is taken while idle. An influence whose bone is in range
// reads its 12 bone words one at a time from the store; each row's three matrix
// words pass read, multiply and accumulate steps and its fourth word is added in
// before the row is weighted. The last influence then runs the iterative
// renormalizer (1 to 30 scaling steps, 4 sum-of-squares steps, 32-step square
// root, 3 x 18-step division, handoff); a zero normal skips its iterative steps.
// Reset clears the accumulators and the output valid flag; the bone store holds
// garbage until written. When the receiver stalls, the result stays in the
// output register, the next vertex is still accepted and processed, and its
// result waits until the register is free.
module linear_blend_vertex_skinning_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // bone, elem, mat_word, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, weight, zero pad
  input  logic [lbvs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op
  input  logic                             s_axis_tuser,
  // last_influence
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_x, out_y, out_z, unit_nx, unit_ny, unit_nz
  output logic [lbvs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // zero_normal
  output logic                             m_axis_tuser
);
  import lbvs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_WMUL  = 4'd4;
  localparam logic [3:0] S_WACC  = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_NWAIT = 4'd7;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if ((&x[65:31]) || !(|x[65:31])) return x[31:0];
    return x[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [64:0] x);
    if (x[64] == x[63]) return x[63:0];
    return x[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic nacc_t sat48(input logic signed [48:0] x);
    if (x[48] == x[47]) return x[47:0];
    return x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  // input fields
  logic [5:0]         in_bone;
  logic [3:0]         in_elem;
  logic [31:0]        in_mat_word;
  logic signed [31:0] in_pos [3];
  logic signed [15:0] in_nrm [3];
  logic [16:0]        in_weight;

  assign in_bone     = s_axis_tdata[5:0];
  assign in_elem     = s_axis_tdata[9:6];
  assign in_mat_word = s_axis_tdata[41:10];
  assign in_pos[0]   = s_axis_tdata[73:42];
  assign in_pos[1]   = s_axis_tdata[105:74];
  assign in_pos[2]   = s_axis_tdata[137:106];
  assign in_nrm[0]   = s_axis_tdata[153:138];
  assign in_nrm[1]   = s_axis_tdata[169:154];
  assign in_nrm[2]   = s_axis_tdata[185:170];
  assign in_weight   = s_axis_tdata[202:186];

  logic [3:0]         state_q;
  logic               first_q;
  logic [5:0]         bone_q;
  logic [16:0]        w_q;
  logic               last_q;
  logic signed [31:0] hpos_q [3];
  logic signed [15:0] hnrm_q [3];
  logic [1:0]         r_q, c_q;
  logic signed [63:0] pp_q;
  logic signed [47:0] pn_q;
  logic signed [65:0] sp_q;
  logic signed [49:0] sn_q;
  logic signed [31:0] t_q, rn_q;
  logic signed [49:0] tw_q, rnw_q;
  logic signed [63:0] accp_q [3];
  nacc_t              accn_q [3];
  logic               m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic               m_user_q;

  // bone store
  logic [31:0]        mem [STORE_DEPTH];
  logic [31:0]        rdata_q;
  logic               in_acc, mem_we, mem_re, bone_ok, elem_ok;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign bone_ok = {3'b000, in_bone} < 9'(MAX_BONES);
  assign elem_ok = {28'd0, in_elem} < 32'(WORDS_PER_BONE);
  assign mem_we  = in_acc && !s_axis_tuser && bone_ok && elem_ok;
  assign mem_re  = (state_q == S_RD);
  assign wr_addr = ADDR_W'(in_bone) * ADDR_W'(WORDS_PER_BONE) + ADDR_W'(in_elem);
  assign rd_addr = ADDR_W'(bone_q) * ADDR_W'(WORDS_PER_BONE) + ADDR_W'({r_q, c_q});

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= in_mat_word;
    if (mem_re) rdata_q <= mem[rd_addr];
  end

  // datapath helpers
  logic signed [31:0] m_s;
  logic signed [65:0] spr;
  logic signed [49:0] snr;
  logic signed [50:0] tsum;
  logic signed [17:0] wsx;
  logic signed [49:0] rnwr;
  logic signed [64:0] psum;
  logic signed [48:0] nsum;
  logic signed [64:0] oround [3];
  logic signed [31:0] opos [3];

  always_comb begin
    m_s  = rdata_q;
    spr  = sp_q + 66'sd32768;
    snr  = sn_q + 50'sd32768;
    tsum = 51'($signed(spr[65:16])) + 51'(m_s);
    wsx  = {1'b0, w_q};
    rnwr = rnw_q + 50'sd32768;
    psum = 65'(accp_q[r_q]) + 65'(tw_q);
    nsum = 49'(accn_q[r_q]) + 49'($signed(rnwr[49:16]));
    for (int i = 0; i < 3; i++) begin
      oround[i] = 65'(accp_q[i]) + 65'sd32768;
      opos[i]   = sat32(66'($signed(oround[i][64:16])));
    end
  end

  nstat_t nstat;
  unit_t  unx, uny, unz;

  lbvs_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_FIN),
    .acc_x_i  (accn_q[0]),
    .acc_y_i  (accn_q[1]),
    .acc_z_i  (accn_q[2]),
    .stat_o   (nstat),
    .unit_x_o (unx),
    .unit_y_o (uny),
    .unit_z_o (unz)
  );

  logic load_out;
  assign load_out = (state_q == S_NWAIT) && nstat.done && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      first_q   <= 1'b1;
      m_valid_q <= 1'b0;
      r_q       <= '0;
      c_q       <= '0;
      sp_q      <= '0;
      sn_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        accp_q[i] <= '0;
        accn_q[i] <= '0;
        hpos_q[i] <= '0;
        hnrm_q[i] <= '0;
      end
    end else begin
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tuser) begin
            bone_q  <= in_bone;
            w_q     <= in_weight;
            last_q  <= s_axis_tlast;
            first_q <= 1'b0;
            if (first_q) begin
              for (int i = 0; i < 3; i++) begin
                hpos_q[i] <= in_pos[i];
                hnrm_q[i] <= in_nrm[i];
              end
            end
            r_q  <= '0;
            c_q  <= '0;
            sp_q <= '0;
            sn_q <= '0;
            if (bone_ok) begin
              state_q <= S_RD;
            end else if (s_axis_tlast) begin
              state_q <= S_FIN;
            end
          end
        end
        S_RD: state_q <= S_MUL;
        S_MUL: begin
          if (c_q == 2'd3) begin
            t_q     <= sat32(66'(tsum));
            rn_q    <= sat32(66'($signed(snr[49:16])));
            state_q <= S_WMUL;
          end else begin
            pp_q    <= m_s * hpos_q[c_q];
            pn_q    <= m_s * hnrm_q[c_q];
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          sp_q    <= sp_q + 66'(pp_q);
          sn_q    <= sn_q + 50'(pn_q);
          c_q     <= c_q + 2'd1;
          state_q <= S_RD;
        end
        S_WMUL: begin
          tw_q    <= t_q * wsx;
          rnw_q   <= rn_q * wsx;
          state_q <= S_WACC;
        end
        S_WACC: begin
          accp_q[r_q] <= sat64(psum);
          accn_q[r_q] <= sat48(nsum);
          sp_q <= '0;
          sn_q <= '0;
          c_q  <= '0;
          if (r_q == 2'd2) begin
            state_q <= last_q ? S_FIN : S_IDLE;
          end else begin
            r_q     <= r_q + 2'd1;
            state_q <= S_RD;
          end
        end
        S_FIN: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (load_out) begin
            m_data_q <= {unz, uny, unx, opos[2], opos[1], opos[0]};
            m_user_q <= nstat.zero;
            first_q  <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              accp_q[i] <= '0;
              accn_q[i] <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE))
    else $error("bone store written while busy");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_NWAIT))
    else $error("result raised outside finish");

  a_zero_nrm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[143:96] == '0))
    else $error("zero normal with nonzero unit fields");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result dropped");
`endif

endmodule

// ===== bench/tb_linear_blend_vertex_skinning_core.sv =====
// testbench for the linear blend vertex skinning core: bone writes, vertex runs, checked results
`timescale 1ns / 100ps

module tb_linear_blend_vertex_skinning_core;
  import lbvs_pkg::*;

  localparam bit OP_BONE_WRITE = 1'b0;
  localparam bit OP_INFLUENCE  = 1'b1;
  localparam longint ONE_Q16   = 65536;

  typedef struct {
    bit                op;
    bit [5:0]          bone;
    bit [3:0]          elem;
    bit signed [31:0]  mat_word;
    bit signed [31:0]  pos[3];
    bit signed [15:0]  nrm[3];
    bit [16:0]         weight;
    bit                last;
  } skin_item_t;

  typedef struct {
    logic signed [31:0] pos[3];
    logic signed [15:0] unit[3];
    logic               zero_nrm;
  } skinned_vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  linear_blend_vertex_skinning_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  bit [31:0]   bone_words[STORE_DEPTH];
  int          ready_bones[$];
  longint      pos_acc[3];
  longint      nrm_acc[3];
  longint      held_pos[3];
  longint      held_nrm[3];
  bit          vertex_start = 1'b1;
  skinned_vertex_t expected_vertices[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  items_sent = 0;
  bit  failed = 1'b0;

  function automatic longint sat_to(logic signed [67:0] x, int w);
    logic signed [67:0] hi, lo;
    hi = (68'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return longint'(hi);
    if (x < lo) return longint'(lo);
    return longint'(x);
  endfunction

  function automatic logic signed [67:0] round_q16(logic signed [67:0] x);
    return (x + 68'sd32768) >>> 16;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic void renormalize(output logic signed [15:0] unit[3], output logic zero_nrm);
    longint unsigned m, ss, len, n, q;
    longint b[3];
    int k;
    m = 0;
    for (int i = 0; i < 3; i++) if (magnitude(nrm_acc[i]) > m) m = magnitude(nrm_acc[i]);
    zero_nrm = (m == 0);
    for (int i = 0; i < 3; i++) unit[i] = '0;
    if (m == 0) return;
    k = 0;
    if (m < (64'd1 << 29)) begin
      while ((m << k) < (64'd1 << 29)) k++;
      for (int i = 0; i < 3; i++) b[i] = nrm_acc[i] * (longint'(1) << k);
    end else begin
      while ((m >> k) >= (64'd1 << 30)) k++;
      for (int i = 0; i < 3; i++) b[i] = nrm_acc[i] >>> k;
    end
    ss = 0;
    for (int i = 0; i < 3; i++) ss += longint'(b[i] * b[i]);
    len = int_sqrt(ss);
    for (int i = 0; i < 3; i++) begin
      n = magnitude(b[i] * 32768);
      q = (n + len / 2) / len;
      unit[i] = 16'(sat_to(b[i] < 0 ? -longint'(q) : longint'(q), 16));
    end
  endfunction

  // updates the skinning state and returns 1 when the item completes a vertex
  function automatic bit skin_predict(skin_item_t it, output skinned_vertex_t res);
    logic signed [67:0] dot, sum;
    longint row[3], t, rn, w;
    int base;
    res = '{default: '0};
    if (it.op == OP_BONE_WRITE) begin
      if (it.bone < MAX_BONES && it.elem < WORDS_PER_BONE)
        bone_words[it.bone * WORDS_PER_BONE + it.elem] = it.mat_word;
      return 1'b0;
    end
    if (vertex_start) begin
      for (int i = 0; i < 3; i++) begin
        held_pos[i] = it.pos[i];
        held_nrm[i] = it.nrm[i];
      end
    end
    w = it.weight;
    for (int r = 0; r < 3; r++) begin
      base = it.bone * WORDS_PER_BONE + r * 4;
      for (int i = 0; i < 3; i++) row[i] = longint'(signed'(bone_words[base + i]));
      dot = 0;
      for (int i = 0; i < 3; i++) dot += 68'(row[i] * held_pos[i]);
      t = sat_to(round_q16(dot) + longint'(signed'(bone_words[base + 3])), 32);
      sum = 68'(pos_acc[r]) + 68'(t * w);
      pos_acc[r] = sat_to(sum, 64);
      dot = 0;
      for (int i = 0; i < 3; i++) dot += 68'(row[i] * held_nrm[i]);
      rn = sat_to(round_q16(dot), 32);
      nrm_acc[r] = sat_to(68'(nrm_acc[r]) + round_q16(68'(rn * w)), 48);
    end
    if (!it.last) begin
      vertex_start = 1'b0;
      return 1'b0;
    end
    for (int i = 0; i < 3; i++) res.pos[i] = 32'(sat_to(round_q16(68'(pos_acc[i])), 32));
    renormalize(res.unit, res.zero_nrm);
    for (int i = 0; i < 3; i++) begin
      pos_acc[i] = 0;
      nrm_acc[i] = 0;
    end
    vertex_start = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_item(skin_item_t it);
    skinned_vertex_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {5'b0, it.weight, it.nrm[2], it.nrm[1], it.nrm[0],
                      it.pos[2], it.pos[1], it.pos[0], it.mat_word, it.elem, it.bone};
    do @(posedge clk_i); while (!s_axis_tready);
    if (skin_predict(it, res)) expected_vertices.push_back(res);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_vertices.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t unexpected result tdata %h tuser %b", $realtime, m_axis_tdata, m_axis_tuser);
        failed = 1'b1;
      end else begin
        skinned_vertex_t e;
        e = expected_vertices.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_axis_tdata[32*i +: 32] !== e.pos[i]) begin
            $display("%0t pos[%0d] expected %h actual %h", $realtime, i, e.pos[i],
                     m_axis_tdata[32*i +: 32]);
            failed = 1'b1;
          end
          if (m_axis_tdata[96 + 16*i +: 16] !== e.unit[i]) begin
            $display("%0t unit[%0d] expected %h actual %h", $realtime, i, e.unit[i],
                     m_axis_tdata[96 + 16*i +: 16]);
            failed = 1'b1;
          end
        end
        if (m_axis_tuser !== e.zero_nrm) begin
          $display("%0t zero_normal expected %b actual %b", $realtime, e.zero_nrm, m_axis_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic skin_item_t bone_word(int bone, int elem, bit [31:0] value);
    skin_item_t it;
    it = '{default: '0};
    it.op = OP_BONE_WRITE;
    it.bone = 6'(bone);
    it.elem = 4'(elem);
    it.mat_word = value;
    for (int i = 0; i < 3; i++) begin
      it.pos[i] = $urandom();
      it.nrm[i] = 16'($urandom());
    end
    it.weight = 17'($urandom());
    it.last = $urandom_range(1);
    return it;
  endfunction

  function automatic skin_item_t influence(int bone, int weight, bit last);
    skin_item_t it;
    it = '{default: '0};
    it.op = OP_INFLUENCE;
    it.bone = 6'(bone);
    it.elem = 4'($urandom());
    it.mat_word = $urandom();
    it.weight = 17'(weight);
    it.last = last;
    return it;
  endfunction

  function automatic bit [31:0] random_matrix_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($urandom_range(2 * ONE_Q16) - ONE_Q16);
      2: return $urandom_range(1) ? 32'(ONE_Q16) : 32'(-ONE_Q16);
      default: return 32'($urandom_range(16) - 8) <<< 16;
    endcase
  endfunction

  task automatic write_bone(int bone, bit [31:0] words[12]);
    for (int e = 0; e < WORDS_PER_BONE; e++) send_item(bone_word(bone, e, words[e]));
    if (!(bone inside {ready_bones})) ready_bones.push_back(bone);
  endtask

  task automatic write_random_bone(int bone);
    bit [31:0] words[12];
    foreach (words[e]) words[e] = random_matrix_word();
    write_bone(bone, words);
  endtask

  task automatic test_directed();
    bit [31:0] ident[12], extreme[12];
    skin_item_t it;
    foreach (ident[e]) ident[e] = (e == 0 || e == 5 || e == 10) ? 32'(ONE_Q16) : 32'd0;
    foreach (extreme[e]) extreme[e] = e[0] ? 32'h7fffffff : 32'h80000000;
    write_bone(0, ident);
    write_bone(63, extreme);
    send_item(bone_word(17, 15, 32'hffffffff));
    send_item(bone_word(17, 12, 32'h12345678));
    // identity, extreme position and normal
    it = influence(0, ONE_Q16, 1);
    it.pos = '{32'h7fffffff, 32'h80000000, 32'h00010000};
    it.nrm = '{16'h7fff, 16'h8000, 16'h0000};
    send_item(it);
    // saturating matrix and position
    it = influence(63, 17'h1ffff, 1);
    it.pos = '{32'h80000000, 32'h80000000, 32'h7fffffff};
    it.nrm = '{16'h8000, 16'h8000, 16'h7fff};
    send_item(it);
    // zero normal
    it = influence(0, ONE_Q16, 1);
    it.pos = '{32'd5, -32'sd7, 32'd0};
    it.nrm = '{16'd0, 16'd0, 16'd0};
    send_item(it);
    // zero weight, three influences with a bone write after the first
    it = influence(0, 0, 0);
    it.pos = '{32'h00020000, 32'h00030000, -32'sh00010000};
    it.nrm = '{16'd1, -16'sd1, 16'd0};
    send_item(it);
    send_item(bone_word(0, 3, 32'h00050000));
    it = influence(63, ONE_Q16 / 2, 0);
    it.pos = '{32'hffffffff, 32'hffffffff, 32'hffffffff};
    send_item(it);
    send_item(influence(0, ONE_Q16 / 2, 1));
  endtask

  task automatic send_random_vertex();
    skin_item_t it;
    int n;
    n = $urandom_range(4, 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        send_item(bone_word(ready_bones[$urandom_range(ready_bones.size() - 1)],
                            $urandom_range(11), random_matrix_word()));
      it = influence(ready_bones[$urandom_range(ready_bones.size() - 1)],
                     $urandom_range(9) == 0 ? $urandom_range(17'h1ffff) : $urandom_range(ONE_Q16),
                     k == n - 1);
      for (int i = 0; i < 3; i++) begin
        it.pos[i] = $urandom_range(1) ? $urandom() : 32'($urandom_range(20 * ONE_Q16)) - 10 * ONE_Q16;
        it.nrm[i] = $urandom_range(7) == 0 ? 16'd0 : 16'($urandom());
      end
      send_item(it);
    end
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int count, bit pause);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < count) begin
      case ($urandom_range(19))
        0: send_item(bone_word($urandom_range(63), $urandom_range(15, 12), $urandom()));
        1: write_random_bone($urandom_range(63));
        default: send_random_vertex();
      endcase
      if (pause && items_sent - start >= count / 2) begin
        wait_drained();
        pause = 1'b0;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int b = 1; b < 8; b++) write_random_bone($urandom_range(62, 1));
    test_random_phase(38, 50, 480, 1'b1);
    test_random_phase(50, 38, 480, 1'b0);
    test_random_phase(0, 0, 480, 1'b0);
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (!failed) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

endmodule
